@@ rtl/tachometer_period_to_rpm_defines.svh @@
// Assertion macros shared by the tachometer checker.
// No dependencies; the user supplies clk_i and rst_ni in scope.
`ifndef TACHOMETER_PERIOD_TO_RPM_DEFINES_SVH
`define TACHOMETER_PERIOD_TO_RPM_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tpr_pkg.sv @@
// Shared types and constants of the tachometer period-to-RPM block.
// No dependencies.
package tpr_pkg;

  localparam int PPR_W     = 8;
  localparam int MAXRPM_W  = 16;
  localparam int MINPER_W  = 20;
  localparam int TIMEOUT_W = 32;
  localparam int RPM_W     = 16;

  // 60e6 fits in 26 bits; period * ppr fits in 34 bits
  localparam int NUM_W     = 26;
  localparam int PROD_W    = NUM_W + PPR_W;
  localparam int DIV_STEPS = NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [NUM_W-1:0]     RPM_NUM         = 26'd60000000;
  localparam logic [MAXRPM_W-1:0]  DEFAULT_MAX_RPM = 16'd6000;

  // Register reset values
  localparam logic [PPR_W-1:0]     PPR_RST     = 8'd1;
  localparam logic [MAXRPM_W-1:0]  MAXRPM_RST  = 16'd0;
  localparam logic [MINPER_W-1:0]  MINPER_RST  = 20'd500;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 32'd2000000;

  // Register indexes (word address)
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_PPR     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAXRPM  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MINPER  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [PPR_W-1:0]     pulses_per_turn;
    logic [MAXRPM_W-1:0]  max_rpm;
    logic [MINPER_W-1:0]  min_edge_gap;
    logic [TIMEOUT_W-1:0] stop_timeout_us;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic load_mul;
    logic div_step;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic force_zero;
  } status_t;

endpackage

@@ rtl/tachometer_period_to_rpm.sv @@
// Tachometer period-to-RPM converter, top level. Depends on tpr_pkg.
// A tick is taken only when idle; it runs through the multiply, the 26-step
// restoring divider and the output load, the divider skipped when the RPM is
// forced to zero (no period, stopped, or period over 60e6 us); a stalled
// result beat holds the next.
// Reset: asynchronous, active low; clears count and period, registers to defaults.
module tachometer_period_to_rpm import tpr_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             edge_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [RPM_W-1:0] rpm_o,
  output logic             edge_accepted_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  tpr_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tpr_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .edge_req_i      (edge_req_i),
    .status_o        (status),
    .rpm_o           (rpm_o),
    .edge_accepted_o (edge_accepted_o)
  );

endmodule

@@ rtl/tpr_apb_regs.sv @@
// APB configuration registers of the tachometer block.
// Depends on tpr_pkg.
module tpr_apb_regs import tpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [PPR_W-1:0]     ppr_q;
  logic [MAXRPM_W-1:0]  maxrpm_q;
  logic [MINPER_W-1:0]  minper_q;
  logic [TIMEOUT_W-1:0] timeout_q;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  // Write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q     <= PPR_RST;
      maxrpm_q  <= MAXRPM_RST;
      minper_q  <= MINPER_RST;
      timeout_q <= TIMEOUT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_PPR:     ppr_q     <= pwdata[PPR_W-1:0];
        REG_MAXRPM:  maxrpm_q  <= pwdata[MAXRPM_W-1:0];
        REG_MINPER:  minper_q  <= pwdata[MINPER_W-1:0];
        REG_TIMEOUT: timeout_q <= pwdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_PPR:     prdata = {{(32-PPR_W){1'b0}}, ppr_q};
      REG_MAXRPM:  prdata = {{(32-MAXRPM_W){1'b0}}, maxrpm_q};
      REG_MINPER:  prdata = {{(32-MINPER_W){1'b0}}, minper_q};
      REG_TIMEOUT: prdata = timeout_q;
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.pulses_per_turn = ppr_q;
  assign cfg_o.max_rpm         = maxrpm_q;
  assign cfg_o.min_edge_gap    = minper_q;
  assign cfg_o.stop_timeout_us = timeout_q;

endmodule

@@ rtl/tpr_ctrl.sv @@
// Sequencer of the tachometer block: tick intake, divide steps, result beat.
// Depends on tpr_pkg.
module tpr_ctrl import tpr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.load_mul = 1'b1;
        cnt_d          = '0;
        state_d        = status_i.force_zero ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the result beat until taken
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/tpr_datapath.sv @@
// Datapath of the tachometer block: edge counter, period store, multiplier,
// restoring divider and output register. Depends on tpr_pkg.
module tpr_datapath import tpr_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  cmd_t             cmd_i,
  input  logic             edge_req_i,
  output status_t          status_o,
  output logic [RPM_W-1:0] rpm_o,
  output logic             edge_accepted_o
);

  localparam int CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  logic [COUNT_WIDTH-1:0] count_q, period_q, count_inc;
  logic                   hit, acc_q;
  logic [CMP_W-1:0]       count_ext, period_ext;
  logic [PPR_W-1:0]       ppr_eff;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W-1:0]      divisor_q;
  logic [PROD_W-1:0]      rem_q;
  logic [NUM_W-1:0]       quo_q;
  logic                   zero_q;
  logic [PROD_W:0]        shifted;
  logic                   ge;
  logic [MAXRPM_W-1:0]    lim;
  logic                   too_fast;
  logic [RPM_W-1:0]       rpm_q;
  logic                   ea_q;

  // Saturating tick count and edge check
  assign count_inc = (count_q == {COUNT_WIDTH{1'b1}}) ? count_q : count_q + 1'b1;
  assign hit = edge_req_i &&
               (count_inc >= {{(COUNT_WIDTH-MINPER_W){1'b0}}, cfg_i.min_edge_gap});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      period_q <= '0;
    end else if (cmd_i.accept) begin
      count_q <= hit ? '0 : count_inc;
      if (hit) begin
        period_q <= count_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      acc_q <= hit;
    end
  end

  // Zero cases: no period, stopped, period beyond the numerator
  assign count_ext  = CMP_W'(count_q);
  assign period_ext = CMP_W'(period_q);
  assign status_o.force_zero = (period_q == '0) ||
                               (count_ext > CMP_W'(cfg_i.stop_timeout_us)) ||
                               (period_ext > CMP_W'(RPM_NUM));

  // Divisor = period * ppr, ppr of zero counts as one
  assign ppr_eff = (cfg_i.pulses_per_turn == '0) ? PPR_W'(1) : cfg_i.pulses_per_turn;
  assign prod    = PROD_W'(period_ext[NUM_W-1:0]) * PROD_W'(ppr_eff);

  // Restoring divide, one quotient bit per step
  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign ge      = (shifted >= {1'b0, divisor_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_mul) begin
      divisor_q <= prod;
      zero_q    <= status_o.force_zero;
      rem_q     <= '0;
      quo_q     <= RPM_NUM;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? PROD_W'(shifted - {1'b0, divisor_q}) : shifted[PROD_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  // Limit check and output register
  assign lim      = (cfg_i.max_rpm == '0) ? DEFAULT_MAX_RPM : cfg_i.max_rpm;
  assign too_fast = (quo_q > NUM_W'(lim));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      rpm_q <= (zero_q || too_fast) ? '0 : quo_q[RPM_W-1:0];
      ea_q  <= acc_q;
    end
  end

  assign rpm_o           = rpm_q;
  assign edge_accepted_o = ea_q;

endmodule

@@ rtl/tpr_checker.sv @@
// Port-level checks of the tachometer block, bound to the top level.
// Depends on tachometer_period_to_rpm_defines.svh.
`include "tachometer_period_to_rpm_defines.svh"

module tpr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] rpm_o,
  input logic        edge_accepted_o
);

  // Hold a stalled result beat
  `TPR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(rpm_o) && $stable(edge_accepted_o), "stalled result beat changed")

  // Take one tick at a time
  `TPR_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "tick accepted while busy")

  // A new result beat follows work in progress
  `TPR_ASSERT_NOW(a_result_after_work, $rose(out_valid_o), $past(in_stall_o), "result beat without a tick in work")

endmodule

bind tachometer_period_to_rpm tpr_checker u_tpr_checker (.*);

@@ test/tb_tachometer_period_to_rpm.sv @@
// Testbench for the tachometer period-to-RPM block: one-microsecond ticks in,
// one RPM reading per tick out, checked against a cycle-free speed tracker.
// Depends on tpr_pkg and the tachometer_period_to_rpm RTL.
module tb_tachometer_period_to_rpm;
  import tpr_pkg::*;

  localparam int COUNT_W = 32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [63:0] RPM_NUMERATOR = 64'd60_000_000;
  localparam logic [63:0] SPEED_CAP_DEFAULT = 64'd6000;
  localparam int ROUNDS = 12;
  localparam int ROUND_TICKS = 104;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [RPM_W-1:0] rpm;
    logic             accepted;
  } tach_reading_t;

  // Tracks shaft speed tick by tick and holds the readings still owed
  class tach_tracker;
    logic [PPR_W-1:0]     ppr;
    logic [MAXRPM_W-1:0]  rpm_cap;
    logic [MINPER_W-1:0]  min_gap;
    logic [TIMEOUT_W-1:0] stop_after;
    logic [COUNT_W-1:0]   since_rise;
    logic [COUNT_W-1:0]   period;
    tach_reading_t        pending[$];
    int unsigned ticks, rises_taken, nonzero_rpm, stopped_ticks, over_cap_ticks;
    int unsigned mismatches;

    function new();
      ppr = PPR_RST;
      rpm_cap = MAXRPM_RST;
      min_gap = MINPER_RST;
      stop_after = TIMEOUT_RST;
      since_rise = '0;
      period = '0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_PPR:     ppr = value[PPR_W-1:0];
        REG_MAXRPM:  rpm_cap = value[MAXRPM_W-1:0];
        REG_MINPER:  min_gap = value[MINPER_W-1:0];
        REG_TIMEOUT: stop_after = value[TIMEOUT_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance one microsecond and queue the reading it produces
    function void note_tick(logic rise);
      tach_reading_t r;
      logic [63:0] prod, quo, cap;
      ticks++;
      if (since_rise != COUNT_MAX) since_rise = since_rise + 1'b1;
      r.accepted = 1'b0;
      if (rise && since_rise >= min_gap) begin
        period = since_rise;
        since_rise = '0;
        r.accepted = 1'b1;
        rises_taken++;
      end
      r.rpm = '0;
      if (period == '0) begin
        // no period stored yet
      end else if (since_rise > stop_after) begin
        stopped_ticks++;
      end else if (period <= RPM_NUMERATOR) begin
        prod = 64'(period);
        prod = prod * ((ppr == '0) ? 64'd1 : {56'd0, ppr});
        quo = RPM_NUMERATOR / prod;
        cap = (rpm_cap == '0) ? SPEED_CAP_DEFAULT : {48'd0, rpm_cap};
        if (quo > cap) over_cap_ticks++;
        else r.rpm = quo[RPM_W-1:0];
      end
      if (r.rpm != '0) nonzero_rpm++;
      pending.push_back(r);
    endfunction

    // Compare one output beat with the oldest owed reading
    function void check_reading(logic [RPM_W-1:0] rpm, logic accepted);
      tach_reading_t want;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: reading with none owed: rpm=%0d accepted=%0b", $time, rpm, accepted);
        return;
      end
      want = pending.pop_front();
      if (rpm !== want.rpm) begin
        mismatches++;
        $display("%0t: rpm mismatch: expected %0d, got %0d", $time, want.rpm, rpm);
      end
      if (accepted !== want.accepted) begin
        mismatches++;
        $display("%0t: edge_accepted mismatch: expected %0b, got %0b",
                 $time, want.accepted, accepted);
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             edge_req_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [RPM_W-1:0] rpm_o;
  logic             edge_accepted_o;
  logic             psel, penable, pwrite;
  logic [3:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  tach_tracker tracker;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_request;
  int hold_left;
  int quiet_cycles;
  int cur_min_gap;
  int settings_used;

  tachometer_period_to_rpm #(.COUNT_WIDTH(COUNT_W)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .edge_req_i      (edge_req_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .rpm_o           (rpm_o),
    .edge_accepted_o (edge_accepted_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Note every beat in both directions at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.note_tick(edge_req_i);
      if (out_valid_o && !out_stall_i) tracker.check_reading(rpm_o, edge_accepted_o);
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, or a long hold-off when asked
  initial begin
    out_stall_i = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offer one tick, idling first at random; returns at the falling edge
  task automatic offer_tick(input logic rise);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      edge_req_i <= 1'($urandom_range(1));
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    edge_req_i <= rise;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Offer n ticks, edge flags taken LSB first from pattern
  task automatic offer_ticks(input int n, input logic [31:0] pattern);
    for (int k = 0; k < n; k++) offer_tick(pattern[k]);
  endtask

  // Drop valid and wait until every owed reading is back, then settle
  task automatic drain_readings();
    in_valid_i <= 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Setup then access phase; ends after idling with the bus released
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.write_reg(idx, value);
    @(negedge clk_i);
  endtask

  task automatic write_all(input logic [31:0] ppr_v, input logic [31:0] cap_v,
                           input logic [31:0] gap_v, input logic [31:0] stop_v);
    write_reg(REG_PPR, ppr_v);
    write_reg(REG_MAXRPM, cap_v);
    write_reg(REG_MINPER, gap_v);
    write_reg(REG_TIMEOUT, stop_v);
    cur_min_gap = gap_v;
    settings_used++;
  endtask

  // Edge spacing: mostly just past the minimum (taken as 300 at most), sometimes too early
  function automatic int pick_spacing();
    int base;
    base = (cur_min_gap > 300) ? 300 : cur_min_gap;
    if ($urandom_range(99) < 80) return base + 1 + $urandom_range(12);
    return $urandom_range(base + 1, 1);
  endfunction

  // Mostly well-spaced edge trains, with stray edges mixed in
  task automatic drive_round(input int n, input bit pause_mid);
    int spacing, since;
    logic rise;
    since = 0;
    spacing = pick_spacing();
    for (int k = 0; k < n; k++) begin
      since++;
      rise = (since >= spacing) || ($urandom_range(99) < 3);
      if (since >= spacing) begin
        since = 0;
        spacing = pick_spacing();
      end
      if (pause_mid && k == n / 2) drain_readings();
      offer_tick(rise);
    end
  endtask

  initial begin
    logic [31:0] ppr_v, cap_v, gap_v, stop_v;
    int roll;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    edge_req_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_request = 0;
    quiet_cycles = 0;
    settings_used = 0;
    cur_min_gap = int'(MINPER_RST);
    send_idle_pct = 27;
    recv_idle_pct = 67;
    tracker = new();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: no period yet, and an edge far below the minimum
    offer_ticks(3, 32'b010);
    drain_readings();
    // Zero minimum accepts every edge; period of one is far too fast
    write_all(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    offer_ticks(3, 32'b111);
    drain_readings();
    // Max pulses and cap: a legal reading, stop timeout, short edges, too fast
    write_all(32'd255, 32'd65535, 32'd3, 32'd4);
    offer_ticks(4, 32'b1000);
    offer_ticks(5, 32'b00000);
    offer_ticks(4, 32'b1011);
    drain_readings();

    for (int round = 0; round < ROUNDS; round++) begin
      case (round / 4)
        0: begin send_idle_pct = 27; recv_idle_pct = 67; end
        1: begin send_idle_pct = 67; recv_idle_pct = 27; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      drain_readings();

      roll = $urandom_range(9);
      ppr_v = (roll < 2) ? 32'd0 : $urandom_range(255);
      roll = $urandom_range(9);
      if (roll < 3) cap_v = 32'd0;
      else if (roll < 5) cap_v = 32'd65535;
      else cap_v = $urandom_range(65535);
      roll = $urandom_range(9);
      if (roll < 7) gap_v = $urandom_range(60, 8);
      else if (roll < 9) gap_v = $urandom_range(200, 40);
      else gap_v = $urandom() % (1 << MINPER_W);
      roll = $urandom_range(9);
      if (roll < 2) stop_v = $urandom_range(80);
      else if (roll == 2) stop_v = 32'hFFFF_FFFF;
      else if (roll == 3) stop_v = $urandom();
      else stop_v = $urandom_range(100000, 100);

      // Pin a few rounds to the register extremes
      case (round)
        1: begin gap_v = 32'd0; ppr_v = 32'd255; cap_v = 32'd65535; stop_v = 32'd10; end
        4: begin gap_v = 32'hF_FFFF; ppr_v = 32'd0; cap_v = 32'd0; stop_v = 32'hFFFF_FFFF; end
        7: begin stop_v = 32'd0; ppr_v = 32'd200; end
        default: ;
      endcase
      write_all(ppr_v, cap_v, gap_v, stop_v);

      // Block the output for a long stretch while ticks keep coming
      if (round == 2 || round == 9) hold_request = HOLD_CYCLES;
      drive_round(ROUND_TICKS, round == 6);
    end

    drain_readings();
    $display("Covered %0d ticks over %0d register settings: %0d edges accepted,",
             tracker.ticks, settings_used, tracker.rises_taken);
    $display("%0d nonzero readings, %0d stopped and %0d over-cap readings.",
             tracker.nonzero_rpm, tracker.stopped_ticks, tracker.over_cap_ticks);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tpr_pkg.sv
rtl/tpr_apb_regs.sv
rtl/tpr_ctrl.sv
rtl/tpr_datapath.sv
rtl/tachometer_period_to_rpm.sv
rtl/tpr_checker.sv
test/tb_tachometer_period_to_rpm.sv
